### sv/frq_pkg.sv
package frq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Port field widths
  localparam int TID_W    = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SELECT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [TID_W-1:0] thread_id;
  } in_word_t;

  typedef struct packed {
    logic [TID_W-1:0]    selected_thread;
    logic [STATUS_W-1:0] status;
    logic [ECOUNT_W-1:0] entry_count;
  } out_word_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                add;
    logic                pop;
    logic                rem;
    logic [ID_WIDTH-1:0] id;
  } frq_cmd_t;

endpackage

### sv/fifo_run_queue_with_removal_unit.sv
// The result word of an accepted word is registered and is valid after the edge that accepts it.
// One word per cycle unless the output stalls; each word updates the cell chain in the cycle it is accepted.
// The next word sees the state left by the previous one, so ready drops only on output stall.
// Reset (rst_n low, synchronous): queue emptied, count zero, no result pending.
module fifo_run_queue_with_removal_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  frq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output frq_pkg::out_word_t out_word
);
  import frq_pkg::*;

  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                accept;
  logic                full, empty;
  frq_cmd_t            cmd;
  status_t             status;
  logic [TID_W-1:0]    sel_id;

  logic [QUEUE_DEPTH-1:0]               cell_valid;
  logic [QUEUE_DEPTH-1:0][ID_WIDTH-1:0] cell_id;
  logic [QUEUE_DEPTH-1:0]               cell_found;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);

  // decode the word into a chain command and a status
  always_comb begin
    cmd     = '0;
    cmd.id  = ID_WIDTH'(in_word.thread_id);
    status  = ST_OK;
    sel_id  = '0;
    case (in_word.opcode)
      OP_ADD: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.add = accept;
        end
      end
      OP_SELECT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.pop = accept;
          sel_id  = TID_W'(cell_id[0]);
        end
      end
      OP_REMOVE: begin
        cmd.rem = accept;
        if (!cell_found[QUEUE_DEPTH-1]) begin
          status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // cell chain, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                pv, nv, fi;
    logic [ID_WIDTH-1:0] nid;
    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign fi = 1'b0;
    end else begin : g_mid
      assign pv = cell_valid[i-1];
      assign fi = cell_found[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nv  = 1'b0;
      assign nid = '0;
    end else begin : g_body
      assign nv  = cell_valid[i+1];
      assign nid = cell_id[i+1];
    end
    frq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_valid (pv),
      .next_valid (nv),
      .next_id    (nid),
      .found_in   (fi),
      .found_out  (cell_found[i]),
      .valid      (cell_valid[i]),
      .id         (cell_id[i])
    );
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.add) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop || (cmd.rem && cell_found[QUEUE_DEPTH-1])) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (accept) begin
      out_valid_nxt                = 1'b1;
      out_word_nxt.selected_thread = sel_id;
      out_word_nxt.status          = status;
      out_word_nxt.entry_count     = ECOUNT_W'(count_nxt);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### sv/frq_cell.sv
module frq_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  frq_pkg::frq_cmd_t             cmd,
  input  logic                          prev_valid,
  input  logic                          next_valid,
  input  logic [frq_pkg::ID_WIDTH-1:0]  next_id,
  input  logic                          found_in,
  output logic                          found_out,
  output logic                          valid,
  output logic [frq_pkg::ID_WIDTH-1:0]  id
);
  import frq_pkg::*;

  logic                valid_r, valid_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic                match;
  logic                take_next;

  // earliest-match chain: on a remove, a cell shifts once it or an earlier cell matched
  assign match     = valid_r && (id_r == cmd.id);
  assign found_out = found_in || match;
  assign take_next = cmd.pop || (cmd.rem && found_out);

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    if (take_next) begin
      valid_nxt = next_valid;
      id_nxt    = next_id;
    end else if (cmd.add && !valid_r && prev_valid) begin
      // first free slot takes the new word
      valid_nxt = 1'b1;
      id_nxt    = cmd.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign valid = valid_r;
  assign id    = id_r;

endmodule

### sv/frq_checker.sv
module frq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input frq_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_ready,
  input frq_pkg::out_word_t out_word
);
  import frq_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // every accepted word yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted word");

  // full flag only with a full queue, and no thread popped
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_FULL |->
      out_word.entry_count == ECOUNT_W'(QUEUE_DEPTH) && out_word.selected_thread == '0)
    else $error("full status with wrong count");

  // empty flag only with an empty queue, and no thread popped
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_EMPTY |->
      out_word.entry_count == '0 && out_word.selected_thread == '0)
    else $error("empty status with nonzero count");

endmodule

bind fifo_run_queue_with_removal_unit frq_checker u_frq_checker (.*);

### dv/frq_run_queue_checker.sv
module frq_run_queue_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  frq_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  frq_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 expected_left
);
  import frq_pkg::*;

  // Shadow of the run queue, head at index 0
  logic [ID_WIDTH-1:0] run_q[$];
  // Result words predicted but not yet seen on the output
  out_word_t           expected_words[$];

  // Apply one scheduler command to the shadow queue and return its result word
  function automatic out_word_t schedule_op(in_word_t w);
    out_word_t           r;
    logic [ID_WIDTH-1:0] tid;
    int                  pos;
    r   = '0;
    tid = w.thread_id[ID_WIDTH-1:0];
    pos = -1;
    case (w.opcode)
      OP_ADD: begin
        if (run_q.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else run_q.push_back(tid);
      end
      OP_SELECT: begin
        if (run_q.size() == 0) r.status = ST_EMPTY;
        else r.selected_thread = TID_W'(run_q.pop_front());
      end
      OP_REMOVE: begin
        // earliest match wins; later entries keep their order
        for (int i = 0; i < run_q.size(); i++) begin
          if (pos < 0 && run_q[i] == tid) pos = i;
        end
        if (pos < 0) r.status = ST_NOT_FOUND;
        else run_q.delete(pos);
      end
      default: ;  // unused opcode leaves the queue alone
    endcase
    r.entry_count = ECOUNT_W'(run_q.size());
    return r;
  endfunction

  // Compare departing words first, then predict for the arriving one
  always @(posedge clk) begin
    out_word_t exp_w;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      run_q.delete();
      expected_words.delete();
      fail_count    <= 0;
      expected_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %h", out_word);
          errs++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_word.selected_thread !== exp_w.selected_thread) begin
            $error("selected_thread: expected %0d, got %0d",
                   exp_w.selected_thread, out_word.selected_thread);
            errs++;
          end
          if (out_word.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, out_word.status);
            errs++;
          end
          if (out_word.entry_count !== exp_w.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   exp_w.entry_count, out_word.entry_count);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) expected_words.push_back(schedule_op(in_word));
      fail_count    <= fail_count + errs;
      expected_left <= expected_words.size();
    end
  end

endmodule

### dv/tb_fifo_run_queue_with_removal_unit.sv
module tb_fifo_run_queue_with_removal_unit;
  import frq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int              CYCLE_LIMIT = 400000;
  localparam int              PHASE_WORDS = 455;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_word   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_word;

  int fail_count;
  int expected_left;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Receiver hold-off request (written by stimulus) and its countdown
  int hold_seq  = 0;
  int hold_len  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  fifo_run_queue_with_removal_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  frq_run_queue_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_word_t make_word(logic [OP_W-1:0] op, logic [TID_W-1:0] tid);
    in_word_t w;
    w.opcode    = op;
    w.thread_id = tid;
    return w;
  endfunction

  // Random command; ids drawn from a small pool half the time so removes hit
  // and duplicates pile up
  function automatic in_word_t random_word(int add_pct);
    in_word_t w;
    int       r;
    r = $urandom_range(99);
    if (r < 3) w.opcode = OP_UNUSED;
    else if (r < add_pct) w.opcode = OP_ADD;
    else if (r < add_pct + (100 - add_pct) / 2) w.opcode = OP_SELECT;
    else w.opcode = OP_REMOVE;
    if ($urandom_range(1)) w.thread_id = TID_W'($urandom_range(7));
    else w.thread_id = TID_W'($urandom);
    return w;
  endfunction

  // Offer one word, with random idle cycles ahead of it, until accepted
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Alternate fill-heavy and drain-heavy stretches so full and empty both recur
  task automatic random_burst(int n);
    for (int k = 0; k < n; k++) begin
      send_word(random_word(((k / 40) % 2) ? 30 : 70));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, fill to full with extremes and duplicates, removals
    send_word(make_word(OP_SELECT, 8'h00));
    send_word(make_word(OP_REMOVE, 8'h3C));
    send_word(make_word(OP_UNUSED, 8'hFF));
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_word(make_word(OP_ADD, (i == 1) ? 8'hFF : TID_W'((i % 5) * 8'h33)));
    end
    send_word(make_word(OP_ADD, 8'h77));
    send_word(make_word(OP_REMOVE, 8'h66));
    send_word(make_word(OP_REMOVE, 8'h01));
    send_word(make_word(OP_UNUSED, 8'h00));
    send_word(make_word(OP_REMOVE, 8'hFF));
    send_word(make_word(OP_SELECT, 8'hFF));
    drain_results();

    // Random phases with different idle mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 70; end
        default: begin send_idle_pct = 25; recv_stall_pct <= 25; end
      endcase
      if (p == 2) begin
        // long output stall while words keep coming, so the input backs up
        hold_len <= 80;
        hold_seq <= hold_seq + 1;
      end
      random_burst(PHASE_WORDS);
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
